/* src/set_assoc_lru_cache_model_defines.svh */
// Assertion macros shared by the cache model RTL
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define SALC_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define SALC_ASSERT(lbl, clk, rstn, prop, msg)
`define SALC_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* src/salc_pkg.sv */
// Shared constants and types for the set-associative LRU cache model
`timescale 1ns / 1ps
package salc_pkg;
  localparam int DEF_MAX_SET_BITS = 6;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int ADDR_W = 64;
  localparam int TAG_W  = 64;
  localparam int AGE_W  = 32;
  localparam int CNT_W  = 32;

  // register map indexes
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_OFF_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS     = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic rd;   // accept beat: latch address, read set row
    logic clr;  // clearing pass: zero one row
    logic upd;  // lookup: update row, totals and result
  } cmd_t;
endpackage

/* src/set_assoc_lru_cache_model.sv */
// Top level: configuration registers, controller and datapath
//
// Set-associative tag store with LRU replacement. After reset the block
// clears its set memory, one set per cycle, all 2^MAX_SET_BITS sets
// (64 by default) with busy high; register writes are taken meanwhile.
// An item is accepted when start is high and busy low; busy then stays
// high while the set row read at accept is compared, aged and written
// back, so a new item is not taken until the last one is through. The
// result beat is shown on out_valid for one cycle, the same cycle in which
// busy falls, and must be taken then: the receiver cannot stall it.
`timescale 1ns / 1ps
module set_assoc_lru_cache_model #(
  parameter int MAX_SET_BITS = salc_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = salc_pkg::DEF_MAX_WAYS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [salc_pkg::ADDR_W-1:0] in_address,
  output logic                        out_valid,
  output logic                        out_was_hit,
  output logic                        out_was_eviction,
  output logic [2:0]                  out_way_touched,
  output logic [salc_pkg::CNT_W-1:0]  out_hits_so_far,
  output logic [salc_pkg::CNT_W-1:0]  out_misses_so_far,
  output logic [salc_pkg::CNT_W-1:0]  out_evictions_so_far,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import salc_pkg::*;

  logic [2:0] set_bits_r;
  logic [5:0] off_bits_r;
  logic [3:0] ways_r;
  cmd_t                    cmd;
  logic [MAX_SET_BITS-1:0] clr_row;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= 3'd1;
      off_bits_r <= 6'd1;
      ways_r     <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SET_BITS: set_bits_r <= pwdata[2:0];
        REG_OFF_BITS: off_bits_r <= pwdata[5:0];
        REG_WAYS:     ways_r     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_SET_BITS: prdata = {29'd0, set_bits_r};
      REG_OFF_BITS: prdata = {26'd0, off_bits_r};
      REG_WAYS:     prdata = {28'd0, ways_r};
      default:      prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  salc_ctrl #(.MAX_SET_BITS(MAX_SET_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cmd(cmd), .clr_row(clr_row)
  );

  salc_dp #(.MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .clr_row(clr_row),
    .in_address(in_address), .cfg_set_bits(set_bits_r),
    .cfg_offset_bits(off_bits_r), .cfg_ways(ways_r),
    .out_valid(out_valid), .out_was_hit(out_was_hit),
    .out_was_eviction(out_was_eviction), .out_way_touched(out_way_touched),
    .out_hits_so_far(out_hits_so_far), .out_misses_so_far(out_misses_so_far),
    .out_evictions_so_far(out_evictions_so_far)
  );
endmodule

/* src/salc_ctrl.sv */
// Controller: clearing pass after reset and per-item sequencing
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_model_defines.svh"
module salc_ctrl #(
  parameter int MAX_SET_BITS = 6
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  output salc_pkg::cmd_t          cmd,
  output logic [MAX_SET_BITS-1:0] clr_row
);
  import salc_pkg::*;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [MAX_SET_BITS-1:0] LAST_ROW = {MAX_SET_BITS{1'b1}};

  logic [1:0]              state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_ROW) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.rd    = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.upd   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign busy    = (state_r != S_IDLE);
  assign clr_row = cnt_r;

  `SALC_ASSERT(a_accept_look, clk, rst_n, (start && !busy) |=> (state_r == S_LOOK), "no lookup after accept")
  `SALC_ASSERT(a_look_one, clk, rst_n, (state_r == S_LOOK) |=> (state_r == S_IDLE), "lookup not single cycle")
  `SALC_NEVER(a_clr_once, clk, rst_n, (state_r == S_CLR) && $past(state_r == S_IDLE), "clear pass reentered")
endmodule

/* src/salc_dp.sv */
// Datapath: set memories, tag compare, LRU victim pick, totals
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_model_defines.svh"
module salc_dp #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  salc_pkg::cmd_t                cmd,
  input  logic [MAX_SET_BITS-1:0]       clr_row,
  input  logic [salc_pkg::ADDR_W-1:0]   in_address,
  input  logic [2:0]                    cfg_set_bits,
  input  logic [5:0]                    cfg_offset_bits,
  input  logic [3:0]                    cfg_ways,
  output logic                          out_valid,
  output logic                          out_was_hit,
  output logic                          out_was_eviction,
  output logic [2:0]                    out_way_touched,
  output logic [salc_pkg::CNT_W-1:0]    out_hits_so_far,
  output logic [salc_pkg::CNT_W-1:0]    out_misses_so_far,
  output logic [salc_pkg::CNT_W-1:0]    out_evictions_so_far
);
  import salc_pkg::*;

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int WIW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WP  = 1 << $clog2(MAX_WAYS);
  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // set memories, one row per set
  logic [MAX_WAYS-1:0]       vmem_r [NUM_SETS];
  logic [MAX_WAYS*TAG_W-1:0] tmem_r [NUM_SETS];
  logic [MAX_WAYS*AGE_W-1:0] amem_r [NUM_SETS];
  logic [MAX_WAYS-1:0]       vrd_r;
  logic [MAX_WAYS*TAG_W-1:0] trd_r;
  logic [MAX_WAYS*AGE_W-1:0] ard_r;

  logic [TAG_W-1:0]        tag_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [MAX_WAYS-1:0]     use_r;
  logic [CNT_W-1:0]        hits_r, miss_r, evic_r;
  logic                    vld_r, hit_r, ev_r;
  logic [2:0]              way_r;

  // address split at the accept beat
  logic [31:0]             sb32, tot32, w32;
  logic [ADDR_W-1:0]       shifted;
  logic [MAX_SET_BITS-1:0] set_w, smask;
  logic [TAG_W-1:0]        tag_w;
  logic [MAX_WAYS-1:0]     use_w;

  always_comb begin
    sb32 = ({29'd0, cfg_set_bits} > 32'(MAX_SET_BITS)) ? 32'(MAX_SET_BITS)
                                                      : {29'd0, cfg_set_bits};
    shifted = in_address >> cfg_offset_bits;
    for (int i = 0; i < MAX_SET_BITS; i++) smask[i] = (32'(i) < sb32);
    set_w = shifted[MAX_SET_BITS-1:0] & smask;
    tot32 = sb32 + {26'd0, cfg_offset_bits};
    tag_w = (tot32 >= 32'd64) ? '0 : (in_address >> tot32[5:0]);
    if (cfg_ways == 4'd0) w32 = 32'd1;
    else if ({28'd0, cfg_ways} > 32'(MAX_WAYS)) w32 = 32'(MAX_WAYS);
    else w32 = {28'd0, cfg_ways};
    for (int w = 0; w < MAX_WAYS; w++) use_w[w] = (32'(w) < w32);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      tag_r <= tag_w;
      set_r <= set_w;
      use_r <= use_w;
      vrd_r <= vmem_r[set_w];
      trd_r <= tmem_r[set_w];
      ard_r <= amem_r[set_w];
    end
  end

  // lookup: age, compare, pick victim
  logic [MAX_WAYS-1:0]       live, match;
  logic [MAX_WAYS*AGE_W-1:0] age_up;
  logic                      hit, have_empty;
  logic [WIW-1:0]            hit_way, empty_way, target;
  logic                      nd_have [2*WP];
  logic [AGE_W-1:0]          nd_age  [2*WP];
  logic [WIW-1:0]            nd_idx  [2*WP];
  logic [MAX_WAYS-1:0]       vwr;
  logic [MAX_WAYS*TAG_W-1:0] twr;
  logic [MAX_WAYS*AGE_W-1:0] awr;

  always_comb begin
    hit = 1'b0; hit_way = '0; have_empty = 1'b0; empty_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      live[w]  = use_r[w] & vrd_r[w];
      match[w] = live[w] && (trd_r[w*TAG_W +: TAG_W] == tag_r);
      if (match[w]) age_up[w*AGE_W +: AGE_W] = '0;
      else if (live[w] && ard_r[w*AGE_W +: AGE_W] != AGE_MAX)
        age_up[w*AGE_W +: AGE_W] = ard_r[w*AGE_W +: AGE_W] + 1'b1;
      else age_up[w*AGE_W +: AGE_W] = ard_r[w*AGE_W +: AGE_W];
    end
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin hit = 1'b1; hit_way = WIW'(w); end
      if (use_r[w] && !vrd_r[w]) begin have_empty = 1'b1; empty_way = WIW'(w); end
    end
    // max-age tree, lower way wins a tie
    for (int n = 0; n < 2 * WP; n++) begin
      nd_have[n] = 1'b0; nd_age[n] = '0; nd_idx[n] = '0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      nd_have[WP+w] = live[w];
      nd_age[WP+w]  = age_up[w*AGE_W +: AGE_W];
      nd_idx[WP+w]  = WIW'(w);
    end
    for (int n = WP - 1; n >= 1; n--) begin
      if (!nd_have[2*n] || (nd_have[2*n+1] && nd_age[2*n+1] > nd_age[2*n])) begin
        nd_have[n] = nd_have[2*n+1]; nd_age[n] = nd_age[2*n+1]; nd_idx[n] = nd_idx[2*n+1];
      end else begin
        nd_have[n] = nd_have[2*n]; nd_age[n] = nd_age[2*n]; nd_idx[n] = nd_idx[2*n];
      end
    end
    if (hit) target = hit_way;
    else if (have_empty) target = empty_way;
    else target = nd_idx[1];
    vwr = vrd_r; twr = trd_r; awr = age_up;
    if (!hit) begin
      vwr[target] = 1'b1;
      twr[target*TAG_W +: TAG_W] = tag_r;
      awr[target*AGE_W +: AGE_W] = '0;
    end
  end

  // memory writes: clearing pass or row update
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      vmem_r[clr_row] <= '0;
      amem_r[clr_row] <= '0;
    end else if (cmd.upd) begin
      vmem_r[set_r] <= vwr;
      tmem_r[set_r] <= twr;
      amem_r[set_r] <= awr;
    end
  end

  // totals and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0; miss_r <= '0; evic_r <= '0; vld_r <= 1'b0;
    end else begin
      vld_r <= cmd.upd;
      if (cmd.upd) begin
        if (hit && hits_r != CNT_MAX) hits_r <= hits_r + 1'b1;
        if (!hit && miss_r != CNT_MAX) miss_r <= miss_r + 1'b1;
        if (!hit && !have_empty && evic_r != CNT_MAX) evic_r <= evic_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      hit_r <= hit;
      ev_r  <= !hit && !have_empty;
      way_r <= 3'(32'(target));
    end
  end

  assign out_valid            = vld_r;
  assign out_was_hit          = hit_r;
  assign out_was_eviction     = ev_r;
  assign out_way_touched      = way_r;
  assign out_hits_so_far      = hits_r;
  assign out_misses_so_far    = miss_r;
  assign out_evictions_so_far = evic_r;

  `SALC_NEVER(a_hit_evict, clk, rst_n, out_valid && out_was_hit && out_was_eviction, "hit with eviction")
  `SALC_ASSERT(a_res_after_look, clk, rst_n, out_valid |-> $past(cmd.upd), "result without lookup")
  `SALC_ASSERT(a_hit_count, clk, rst_n, (out_valid && out_was_hit && $past(hits_r) != CNT_MAX) |-> (hits_r == $past(hits_r) + 1'b1), "hit total not advanced")
endmodule

/* tb/tb_set_assoc_lru_cache_model.sv */
// Testbench for the set-associative LRU tag store: directed and random lookups
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_model;
  import salc_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [63:0] in_address = '0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        busy, out_valid, out_was_hit, out_was_eviction, pready;
  logic [2:0]  out_way_touched;
  logic [31:0] out_hits_so_far, out_misses_so_far, out_evictions_so_far, prdata;

  set_assoc_lru_cache_model uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_address(in_address),
    .out_valid(out_valid), .out_was_hit(out_was_hit), .out_was_eviction(out_was_eviction),
    .out_way_touched(out_way_touched), .out_hits_so_far(out_hits_so_far),
    .out_misses_so_far(out_misses_so_far), .out_evictions_so_far(out_evictions_so_far),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    bit        hit;
    bit        evict;
    bit [2:0]  way;
    bit [31:0] hits;
    bit [31:0] misses;
    bit [31:0] evicts;
  } lookup_t;

  // predictor state
  bit        tag_valid [NSETS*NWAYS];
  bit [63:0] tag_store [NSETS*NWAYS];
  bit [31:0] tag_age   [NSETS*NWAYS];
  bit [31:0] hit_cnt, miss_tot, evict_tot;
  bit [2:0]  set_bits_q = 3'd1;
  bit [5:0]  off_bits_q = 6'd1;
  bit [3:0]  ways_q = 4'd1;

  lookup_t expected_q[$];
  int      fail_cnt = 0;
  int      n_items = 0;
  int      n_results = 0;
  int      n_hits = 0;
  int      n_evicts = 0;
  bit      no_gaps = 1'b0;

  function automatic bit [31:0] sat_add1(bit [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // one lookup: age the set, match, fill on miss
  function automatic lookup_t predict_lookup(bit [63:0] a);
    int unsigned sb, ob, nw, setv, base, ts, k, hit_way, empty_way, old_way, tgt;
    bit [31:0] old_age;
    bit        hit, have_empty, have_old;
    bit [63:0] tg;
    lookup_t   r;
    sb = (set_bits_q > 6) ? 6 : set_bits_q;
    ob = off_bits_q;
    nw = (ways_q == 0) ? 1 : ((ways_q > 8) ? 8 : ways_q);
    setv = 32'((a >> ob) & ((64'd1 << sb) - 1));
    ts = sb + ob;
    tg = (ts >= 64) ? 64'd0 : (a >> ts);
    base = setv * NWAYS;
    hit = 0; have_empty = 0; have_old = 0;
    hit_way = 0; empty_way = 0; old_way = 0; old_age = 0;
    for (int w = 0; w < nw; w++) begin
      k = base + w;
      if (tag_valid[k]) begin
        tag_age[k] = sat_add1(tag_age[k]);
        if (tag_store[k] == tg) begin
          if (!hit) hit_way = w;
          hit = 1;
          tag_age[k] = 0;
        end
        if (!have_old || tag_age[k] > old_age) begin
          have_old = 1;
          old_age = tag_age[k];
          old_way = w;
        end
      end else if (!have_empty) begin
        have_empty = 1;
        empty_way = w;
      end
    end
    r.evict = 0;
    if (hit) begin
      hit_cnt = sat_add1(hit_cnt);
      tgt = hit_way;
    end else begin
      miss_tot = sat_add1(miss_tot);
      tgt = have_empty ? empty_way : old_way;
      if (tag_valid[base + tgt]) begin
        r.evict = 1;
        evict_tot = sat_add1(evict_tot);
      end
      tag_valid[base + tgt] = 1;
      tag_store[base + tgt] = tg;
      tag_age[base + tgt] = 0;
    end
    r.hit = hit;
    r.way = tgt[2:0];
    r.hits = hit_cnt;
    r.misses = miss_tot;
    r.evicts = evict_tot;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    lookup_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result beat with no lookup outstanding");
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (e.hit) n_hits++;
        if (e.evict) n_evicts++;
        if (out_was_hit !== e.hit) begin
          $error("was_hit exp %0d got %0d", e.hit, out_was_hit); fail_cnt++;
        end
        if (out_was_eviction !== e.evict) begin
          $error("was_eviction exp %0d got %0d", e.evict, out_was_eviction); fail_cnt++;
        end
        if (out_way_touched !== e.way) begin
          $error("way_touched exp %0d got %0d", e.way, out_way_touched); fail_cnt++;
        end
        if (out_hits_so_far !== e.hits) begin
          $error("hits_so_far exp %0d got %0d", e.hits, out_hits_so_far); fail_cnt++;
        end
        if (out_misses_so_far !== e.misses) begin
          $error("misses_so_far exp %0d got %0d", e.misses, out_misses_so_far); fail_cnt++;
        end
        if (out_evictions_so_far !== e.evicts) begin
          $error("evictions_so_far exp %0d got %0d", e.evicts, out_evictions_so_far);
          fail_cnt++;
        end
      end
    end
  end

  // send one address beat; start stays high afterwards
  task automatic send_addr(bit [63:0] a);
    start <= 1'b1;
    in_address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_lookup(a));
    n_items++;
  endtask

  task automatic idle_gap();
    int g;
    int pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 50) g = 0;
    else if (pick < 90) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_reg(logic [1:0] idx, bit [31:0] val);
    bit [31:0] mask;
    mask = (idx == REG_SET_BITS) ? 32'h7 : ((idx == REG_OFF_BITS) ? 32'h3F : 32'hF);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_SET_BITS: set_bits_q = val[2:0];
      REG_OFF_BITS: off_bits_q = val[5:0];
      default:      ways_q = val[3:0];
    endcase
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (val & mask)) begin
      $error("reg %0d readback exp %0h got %0h", idx, val & mask, prdata & mask);
      fail_cnt++;
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(bit [2:0] sb, bit [5:0] ob, bit [3:0] nw);
    wait_drained();
    write_reg(REG_SET_BITS, {$urandom} & ~32'h7 | sb);
    write_reg(REG_OFF_BITS, {$urandom} & ~32'h3F | ob);
    write_reg(REG_WAYS, {$urandom} & ~32'hF | nw);
  endtask

  function automatic bit [63:0] make_addr(bit [63:0] tg, int unsigned setv, bit [63:0] off);
    int unsigned sb, ob;
    bit [63:0] a;
    sb = (set_bits_q > 6) ? 6 : set_bits_q;
    ob = off_bits_q;
    a = (off & ((64'd1 << ob) - 1)) | ((64'(setv) & ((64'd1 << sb) - 1)) << ob);
    if (sb + ob < 64) a = a | (tg << (sb + ob));
    return a;
  endfunction

  // reset register values, hits and misses in a two-set cache
  task automatic test_reset_config();
    send_addr(64'h0); idle_gap();
    send_addr(64'h1); idle_gap();
    send_addr(64'h2); idle_gap();
    send_addr(64'h4); idle_gap();
    send_addr(64'h0); idle_gap();
  endtask

  // field and register extremes, out-of-range values, huge offsets
  task automatic test_extremes();
    set_config(3'd7, 6'd0, 4'd15);
    send_addr(64'h0); idle_gap();
    send_addr('1); idle_gap();
    send_addr(64'hAAAA_AAAA_AAAA_AAAA); idle_gap();
    send_addr(64'h5555_5555_5555_5555); idle_gap();
    send_addr('1); idle_gap();
    set_config(3'd0, 6'd63, 4'd0);
    send_addr(64'h0); idle_gap();
    send_addr(64'h8000_0000_0000_0000); idle_gap();
    send_addr(64'h1234); idle_gap();
    set_config(3'd6, 6'd60, 4'd8);
    send_addr('1); idle_gap();
    send_addr(64'h0); idle_gap();
    send_addr(64'h7FFF_FFFF_FFFF_FFFF); idle_gap();
  endtask

  // same tag in two ways after the way count shrinks and grows again
  task automatic test_duplicate_tags();
    set_config(3'd1, 6'd4, 4'd2);
    send_addr(make_addr(64'd10, 1, 0));
    send_addr(make_addr(64'd11, 1, 3));
    set_config(3'd1, 6'd4, 4'd1);
    send_addr(make_addr(64'd11, 1, 5));
    set_config(3'd1, 6'd4, 4'd2);
    send_addr(make_addr(64'd11, 1, 7));
    send_addr(make_addr(64'd12, 1, 0));
    send_addr(make_addr(64'd11, 1, 0));
  endtask

  // random phases: mostly reused tags on a few sets, some arbitrary addresses
  task automatic test_random();
    bit [2:0]  sb;
    bit [5:0]  ob;
    bit [3:0]  nw;
    int unsigned setv;
    bit [63:0] a;
    for (int ph = 0; ph < 6; ph++) begin
      sb = (ph == 0) ? 3'd2 : 3'($urandom_range(0, 7));
      ob = (ph == 1) ? 6'd63 : ($urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 8)));
      nw = (ph == 2) ? 4'd15 : 4'($urandom_range(0, 15));
      set_config(sb, ob, nw);
      no_gaps = (ph == 3);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          a = {$urandom, $urandom};
        end else begin
          setv = $urandom_range(0, 3);
          a = make_addr(64'($urandom_range(0, 11)), setv, {$urandom, $urandom});
        end
        send_addr(a);
        if (i == 50) wait_drained();
        else idle_gap();
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_extremes();
    test_duplicate_tags();
    test_random();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("covered %0d lookups, %0d results: %0d hits, %0d evictions", n_items,
             n_results, n_hits, n_evicts);
    $display("register extremes, duplicate tags and back-to-back beats were exercised");
    if (fail_cnt == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (expected_q.size() != 0) $error("%0d lookups never answered", expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

/* set_assoc_lru_cache_model.f */
+incdir+src
src/salc_pkg.sv
src/salc_ctrl.sv
src/salc_dp.sv
src/set_assoc_lru_cache_model.sv
tb/tb_set_assoc_lru_cache_model.sv
